[rtl/core/lcbc_pkg.sv]
// Shared constants, codes and control structs of the lamp command byte controller.
package lcbc_pkg;

   // Protocol bytes.
   localparam logic [7:0] BYTE_COUNT = 8'd150;
   localparam logic [7:0] BYTE_GET   = 8'd160;
   localparam logic [7:0] BYTE_SET   = 8'd170;
   localparam logic [7:0] BYTE_EXEC  = 8'd198;

   // A brightness value is valid when it lies below this limit.
   localparam logic [7:0] VALUE_LIMIT = 8'd101;

   localparam int         DEF_MAX_LAMPS    = 8;
   localparam logic [3:0] LAMP_COUNT_RESET = 4'd8;

   // Register indexes, taken from address bit 2.
   localparam logic REG_LAMP_COUNT   = 1'b0;
   localparam logic REG_INDEX_OFFSET = 1'b1;

   // Result kinds.
   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   typedef enum logic [1:0] {
      EMIT_COUNT = 2'd0,
      EMIT_TABLE = 2'd1,
      EMIT_TAIL  = 2'd2,
      EMIT_SET   = 2'd3
   } emit_sel_type;

   typedef struct packed {
      logic [3:0] lamp_count;
      logic [7:0] index_offset;
   } cfg_type;

   typedef struct packed {
      logic         load_value;
      logic         load_index;
      logic         clear_pending;
      logic         start;
      logic         cnt_inc;
      logic         mem_wr;
      logic         emit;
      emit_sel_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic is_count;
      logic is_get;
      logic is_set;
      logic is_exec;
      logic idx_ok;
      logic val_ok;
      logic n_zero;
      logic out_free;
      logic at_end;
   } sts_type;

endpackage

[rtl/core/lcbc_req_if.sv]
// Input channel carrying one received byte per item.
interface lcbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/lcbc_rsp_if.sv]
// Result channel carrying answer bytes and lamp update events.
interface lcbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [2:0] lamp_index;
   logic       last;

   modport source (output valid, output kind, output data_byte, output lamp_index,
                   output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input lamp_index,
                   input last, output ready);
endinterface

[rtl/core/lcbc_csr.sv]
// Configuration registers behind the APB-style port.
module lcbc_csr
   import lcbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic [3:0] lamp_count_ff, lamp_count_in;
   logic [7:0] index_offset_ff, index_offset_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      lamp_count_in   = lamp_count_ff;
      index_offset_in = index_offset_ff;
      if (wr_en) begin
         if (paddr[2] == REG_LAMP_COUNT) begin
            lamp_count_in = pwdata[3:0];
         end else begin
            index_offset_in = pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_count_ff   <= LAMP_COUNT_RESET;
         index_offset_ff <= 8'd0;
      end else begin
         lamp_count_ff   <= lamp_count_in;
         index_offset_ff <= index_offset_in;
      end
   end

   always_comb begin
      if (paddr[2] == REG_INDEX_OFFSET) begin
         prdata = {24'd0, index_offset_ff};
      end else begin
         prdata = {28'd0, lamp_count_ff};
      end
   end

   assign cfg.lamp_count   = lamp_count_ff;
   assign cfg.index_offset = index_offset_ff;

endmodule

[rtl/core/lcbc_datapath.sv]
// Datapath: pending parameters, brightness table, lamp counter and result register.
module lcbc_datapath
   import lcbc_pkg::*;
#(
   parameter int MAX_LAMPS = DEF_MAX_LAMPS
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output sts_type    sts,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_lamp_index,
   output logic       rsp_last
);

   localparam int IDX_W = (MAX_LAMPS > 1) ? $clog2(MAX_LAMPS) : 1;

   logic [3:0]        lamps_n;
   logic signed [8:0] rx_idx;
   logic signed [8:0] pend_idx_ff, pend_idx_in;
   logic signed [8:0] pend_val_ff, pend_val_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              single_ff, single_in;
   logic [6:0]        val_ff, val_in;
   logic              idx_ok, val_ok;

   logic [6:0]           mem [MAX_LAMPS];
   logic [MAX_LAMPS-1:0] vld_ff;
   logic [6:0]           rd_data_ff;
   logic                 rd_vld_ff;
   logic [6:0]           table_value;

   logic       out_valid_ff, out_valid_in;
   logic       out_kind_ff, out_kind_in;
   logic [7:0] out_data_ff, out_data_in;
   logic [2:0] out_idx_ff, out_idx_in;
   logic       out_last_ff, out_last_in;
   logic       out_free;
   logic       at_end;

   // The count in use never exceeds the table depth.
   always_comb begin
      if ({3'b000, cfg.lamp_count} > 7'(MAX_LAMPS)) begin
         lamps_n = 4'(MAX_LAMPS);
      end else begin
         lamps_n = cfg.lamp_count;
      end
   end

   assign rx_idx = $signed({1'b0, rx_byte}) - $signed({1'b0, cfg.index_offset});

   assign idx_ok = !pend_idx_ff[8] && (pend_idx_ff[7:0] < {4'd0, lamps_n});
   assign val_ok = !pend_val_ff[8] && (pend_val_ff[7:0] < VALUE_LIMIT);

   always_comb begin
      pend_idx_in = pend_idx_ff;
      pend_val_in = pend_val_ff;
      if (cmd.clear_pending) begin
         pend_idx_in = '1;
         pend_val_in = '1;
      end else begin
         if (cmd.load_value) begin
            pend_val_in = $signed({1'b0, rx_byte});
         end
         if (cmd.load_index) begin
            pend_idx_in = rx_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_idx_ff <= '1;
         pend_val_ff <= '1;
      end else begin
         pend_idx_ff <= pend_idx_in;
         pend_val_ff <= pend_val_in;
      end
   end

   // Execute registers: start lamp, single-lamp flag and value to write.
   always_comb begin
      cnt_in    = cnt_ff;
      single_in = single_ff;
      val_in    = val_ff;
      if (cmd.start) begin
         cnt_in    = idx_ok ? pend_idx_ff[IDX_W-1:0] : '0;
         single_in = idx_ok;
         val_in    = pend_val_ff[6:0];
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      single_ff <= single_in;
      val_ff    <= val_in;
   end

   assign at_end = single_ff || ((8'(cnt_ff) + 8'd1) == {4'd0, lamps_n});

   // Brightness table; an entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[cnt_ff] <= val_ff;
      end
      rd_data_ff <= mem[cnt_ff];
      rd_vld_ff  <= vld_ff[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.mem_wr) begin
         vld_ff[cnt_ff] <= 1'b1;
      end
   end

   assign table_value = rd_vld_ff ? rd_data_ff : 7'd0;

   // Result register.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         case (cmd.emit_sel)
            EMIT_COUNT: begin
               out_kind_in = KIND_ANSWER;
               out_data_in = {4'd0, lamps_n};
               out_idx_in  = 3'd0;
               out_last_in = 1'b0;
            end
            EMIT_TABLE: begin
               out_kind_in = KIND_ANSWER;
               out_data_in = {1'b0, table_value};
               out_idx_in  = 3'd0;
               out_last_in = 1'b0;
            end
            EMIT_TAIL: begin
               out_kind_in = KIND_ANSWER;
               out_data_in = BYTE_EXEC;
               out_idx_in  = 3'd0;
               out_last_in = 1'b1;
            end
            default: begin
               out_kind_in = KIND_UPDATE;
               out_data_in = {1'b0, val_ff};
               out_idx_in  = 3'(cnt_ff);
               out_last_in = at_end;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_data_byte  = out_data_ff;
   assign rsp_lamp_index = out_idx_ff;
   assign rsp_last       = out_last_ff;

   assign sts.is_count = (rx_byte == BYTE_COUNT);
   assign sts.is_get   = (rx_byte == BYTE_GET);
   assign sts.is_set   = (rx_byte == BYTE_SET);
   assign sts.is_exec  = (rx_byte == BYTE_EXEC);
   assign sts.idx_ok   = idx_ok;
   assign sts.val_ok   = val_ok;
   assign sts.n_zero   = (lamps_n == 4'd0);
   assign sts.out_free = out_free;
   assign sts.at_end   = at_end;

endmodule

[rtl/core/lcbc_controller.sv]
// Controller: command parser and the sequencer that runs an execute byte.
module lcbc_controller
   import lcbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_COUNT = 6'b000010,
      ST_READ  = 6'b000100,
      ST_GET   = 6'b001000,
      ST_SET   = 6'b010000,
      ST_TAIL  = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_COUNT = 4'b0010,
      MODE_GET   = 4'b0100,
      MODE_SET   = 4'b1000
   } mode_type;

   typedef enum logic [2:0] {
      STG_STARTED = 3'b001,
      STG_VALUE   = 3'b010,
      STG_DONE    = 3'b100
   } stage_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   stage_type stage_ff, stage_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      stage_in = stage_ff;
      cmd      = '0;
      cmd.emit_sel = EMIT_COUNT;
      case (state_ff)
         ST_IDLE: begin
            if (accept && sts.is_exec) begin
               // Every execute byte returns the parser to idle.
               mode_in           = MODE_IDLE;
               stage_in          = STG_STARTED;
               cmd.start         = 1'b1;
               cmd.clear_pending = 1'b1;
               case (mode_ff)
                  MODE_COUNT: state_in = ST_COUNT;
                  MODE_GET: begin
                     state_in = (!sts.idx_ok && sts.n_zero) ? ST_TAIL : ST_READ;
                  end
                  MODE_SET: begin
                     if (sts.val_ok && (sts.idx_ok || !sts.n_zero)) begin
                        state_in = ST_SET;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end else if (accept) begin
               case (mode_ff)
                  MODE_IDLE: begin
                     stage_in = STG_STARTED;
                     if (sts.is_count) begin
                        mode_in = MODE_COUNT;
                     end else if (sts.is_get) begin
                        mode_in = MODE_GET;
                     end else if (sts.is_set) begin
                        mode_in = MODE_SET;
                     end
                  end
                  MODE_GET: begin
                     // After the index byte further parameter bytes are ignored.
                     if (stage_ff == STG_STARTED) begin
                        cmd.load_index = 1'b1;
                        stage_in       = STG_DONE;
                     end
                  end
                  MODE_SET: begin
                     if (stage_ff == STG_STARTED) begin
                        cmd.load_value = 1'b1;
                        stage_in       = STG_VALUE;
                     end else if (stage_ff == STG_VALUE) begin
                        cmd.load_index = 1'b1;
                        stage_in       = STG_DONE;
                     end else begin
                        cmd.clear_pending = 1'b1;
                        mode_in           = MODE_IDLE;
                        stage_in          = STG_STARTED;
                     end
                  end
                  default: begin
                     cmd.clear_pending = 1'b1;
                     mode_in           = MODE_IDLE;
                     stage_in          = STG_STARTED;
                  end
               endcase
            end
         end
         ST_COUNT: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_COUNT;
               state_in     = ST_TAIL;
            end
         end
         ST_READ: begin
            // The table read issued here is registered for the next cycle.
            state_in = ST_GET;
         end
         ST_GET: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_TABLE;
               if (sts.at_end) begin
                  state_in = ST_TAIL;
               end else begin
                  cmd.cnt_inc = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_SET: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_SET;
               cmd.mem_wr   = 1'b1;
               if (sts.at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_TAIL;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_IDLE;
         stage_ff <= STG_STARTED;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         stage_ff <= stage_in;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded while the result register is full");

   a_write_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> (cmd.emit && state_ff == ST_SET))
      else $error("table written without an update event");

   a_no_step_past_end: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !sts.at_end)
      else $error("lamp counter stepped past the last lamp");

   a_bad_value_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && sts.is_exec && mode_ff == MODE_SET && !sts.val_ok) |=> state_ff == ST_IDLE)
      else $error("set with an invalid value started a run");

endmodule

[rtl/core/lamp_command_byte_controller.sv]
// Top level of the lamp command byte controller.
//
// Bytes from a serial link enter on req_chan, one item per byte. Results
// leave on rsp_chan: answer bytes (kind 0) ending in 198, or lamp update
// events (kind 1) with the lamp index; last marks the final result of a byte.
// lamp_count and index_offset are registers at byte addresses 0 and 4 of the
// APB-style port; the user must write them while the block is idle, unenforced.
//
// A parameter byte is accepted whenever the sequencer is idle. An execute
// byte holds req_chan off while its run plays out through the sequencer:
// a count query emits the count, then the tail; a query reads each lamp
// asked for (one, or all n lamps in use) from the single-port brightness
// table and emits it, then the tail; a set writes and emits an update for each
// lamp. A result register parts the two channels; when the receiver stalls,
// the sequencer waits on it. Reset returns the parser to idle and clears the
// brightness table through per-entry valid bits, with no clearing pass.
module lamp_command_byte_controller
   import lcbc_pkg::*;
#(
   parameter int MAX_LAMPS = DEF_MAX_LAMPS
)
(
   input  logic        clock,
   input  logic        reset,
   lcbc_req_if.sink    req_chan,
   lcbc_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_chan.ready = req_ready;

   lcbc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lcbc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lcbc_datapath #(
      .MAX_LAMPS (MAX_LAMPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .rx_byte        (req_chan.rx_byte),
      .cfg            (cfg),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_kind       (rsp_chan.kind),
      .rsp_data_byte  (rsp_chan.data_byte),
      .rsp_lamp_index (rsp_chan.lamp_index),
      .rsp_last       (rsp_chan.last)
   );

endmodule

[tb/sv/lamp_command_byte_controller_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the lamp command byte controller: directed rows, then random runs.
module lamp_command_byte_controller_tb;
   import lcbc_pkg::*;

   localparam int LAMP_SLOTS      = DEF_MAX_LAMPS;
   localparam int IDLE_PERCENT    = 38;
   localparam int ITEMS_PER_PHASE = 25;
   localparam int LONG_HOLD       = 200;
   localparam int SETTLE_CYCLES   = 24;

   localparam logic [2:0] ADDR_LAMP_COUNT   = {REG_LAMP_COUNT, 2'b00};
   localparam logic [2:0] ADDR_INDEX_OFFSET = {REG_INDEX_OFFSET, 2'b00};

   // Any byte outside the command set leaves an idle parser alone.
   localparam logic [7:0] FILLER_BYTE = 8'd199;

   typedef enum logic [1:0] {PARSE_IDLE, PARSE_COUNT, PARSE_GET, PARSE_SET} parse_mode_type;
   typedef enum logic [1:0] {STAGE_START, STAGE_VALUE, STAGE_DONE} parse_stage_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [2:0] lamp_index;
      logic       last;
   } reply_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       typed;
      logic [1:0] n_typed;
      reply_type  first;
      reply_type  second;
   } plan_row_type;

   typedef struct packed {
      logic [3:0] lamps;
      logic [7:0] offset;
      logic       steady;
      logic       squeeze;
   } phase_type;

   localparam reply_type NO_REPLY = '0;

   localparam plan_row_type DIRECTED [27] = '{
      '{BYTE_COUNT,  1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_EXEC,   1'b1, 2'd2, '{KIND_ANSWER, 8'd8, 3'd0, 1'b0},
                                 '{KIND_ANSWER, BYTE_EXEC, 3'd0, 1'b1}},
      '{FILLER_BYTE, 1'b1, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_SET,    1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd100,      1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd7,        1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_EXEC,   1'b1, 2'd1, '{KIND_UPDATE, 8'd100, 3'd7, 1'b1}, NO_REPLY},
      '{BYTE_GET,    1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd7,        1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd255,      1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_EXEC,   1'b1, 2'd2, '{KIND_ANSWER, 8'd100, 3'd0, 1'b0},
                                 '{KIND_ANSWER, BYTE_EXEC, 3'd0, 1'b1}},
      '{BYTE_SET,    1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd0,        1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_EXEC,   1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_SET,    1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{VALUE_LIMIT, 1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_EXEC,   1'b1, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_COUNT,  1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd0,        1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_EXEC,   1'b1, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_SET,    1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd5,        1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd3,        1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{8'd9,        1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_EXEC,   1'b1, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_GET,    1'b0, 2'd0, NO_REPLY, NO_REPLY},
      '{BYTE_EXEC,   1'b0, 2'd0, NO_REPLY, NO_REPLY}
   };

   localparam phase_type PHASES [6] = '{
      '{4'd1,  8'd0,   1'b0, 1'b0},
      '{4'd0,  8'd255, 1'b0, 1'b0},
      '{4'd15, 8'd3,   1'b1, 1'b0},
      '{4'd8,  8'd200, 1'b0, 1'b1},
      '{4'd4,  8'd128, 1'b0, 1'b0},
      '{4'd2,  8'd1,   1'b0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   lcbc_req_if req_link ();
   lcbc_rsp_if rsp_link ();

   lamp_command_byte_controller u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_link),
      .rsp_chan (rsp_link),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #10 clock = ~clock;

   // Copy of the controller state, kept in step with accepted items.
   logic [6:0]        level_copy [LAMP_SLOTS];
   parse_mode_type    mode_copy;
   parse_stage_type   stage_copy;
   logic signed [8:0] index_copy;
   logic signed [8:0] value_copy;
   logic [3:0]        count_cfg;
   logic [7:0]        offset_cfg;

   reply_type replies_due [$];
   reply_type replies_new [$];
   reply_type reply_now;

   int mismatch_count = 0;
   int hold_cycles    = 0;
   int phase_items    = 0;
   bit steady         = 1'b0;

   function automatic void clear_parser();
      index_copy = -9'sd1;
      value_copy = -9'sd1;
      mode_copy  = PARSE_IDLE;
      stage_copy = STAGE_START;
   endfunction

   function automatic int lamps_in_use();
      return (count_cfg > LAMP_SLOTS) ? LAMP_SLOTS : int'(count_cfg);
   endfunction

   function automatic void add_reply(input logic kind, input logic [7:0] data, input int lamp);
      reply_type r;
      r.kind       = kind;
      r.data_byte  = data;
      r.lamp_index = lamp[2:0];
      r.last       = 1'b0;
      replies_new.push_back(r);
   endfunction

   function automatic void run_command();
      int        n;
      bit        index_ok;
      bit        value_ok;
      reply_type tail;
      n        = lamps_in_use();
      index_ok = (index_copy >= 0) && (index_copy < n);
      value_ok = (value_copy >= 0) && (value_copy < int'(VALUE_LIMIT));
      case (mode_copy)
         PARSE_COUNT: begin
            add_reply(KIND_ANSWER, 8'(n), 0);
            add_reply(KIND_ANSWER, BYTE_EXEC, 0);
         end
         PARSE_GET: begin
            if (index_ok) begin
               add_reply(KIND_ANSWER, {1'b0, level_copy[index_copy[2:0]]}, 0);
            end else begin
               for (int i = 0; i < n; i++)
                  add_reply(KIND_ANSWER, {1'b0, level_copy[i]}, 0);
            end
            add_reply(KIND_ANSWER, BYTE_EXEC, 0);
         end
         PARSE_SET: begin
            // An invalid index turns a set into a set of every lamp in use.
            if (value_ok) begin
               for (int i = 0; i < n; i++) begin
                  if (!index_ok || i == index_copy) begin
                     level_copy[i] = value_copy[6:0];
                     add_reply(KIND_UPDATE, value_copy[7:0], i);
                  end
               end
            end
         end
         default: ;
      endcase
      clear_parser();
      if (replies_new.size() > 0) begin
         tail      = replies_new.pop_back();
         tail.last = 1'b1;
         replies_new.push_back(tail);
      end
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      logic signed [8:0] shifted;
      replies_new.delete();
      shifted = $signed({1'b0, b}) - $signed({1'b0, offset_cfg});
      if (b == BYTE_EXEC) begin
         run_command();
         return;
      end
      case (mode_copy)
         PARSE_IDLE: begin
            if (b == BYTE_COUNT)
               mode_copy = PARSE_COUNT;
            else if (b == BYTE_GET)
               mode_copy = PARSE_GET;
            else if (b == BYTE_SET)
               mode_copy = PARSE_SET;
            stage_copy = STAGE_START;
         end
         PARSE_GET: begin
            if (stage_copy == STAGE_START) begin
               index_copy = shifted;
               stage_copy = STAGE_DONE;
            end
         end
         PARSE_SET: begin
            if (stage_copy == STAGE_START) begin
               value_copy = $signed({1'b0, b});
               stage_copy = STAGE_VALUE;
            end else if (stage_copy == STAGE_VALUE) begin
               index_copy = shifted;
               stage_copy = STAGE_DONE;
            end else begin
               clear_parser();
            end
         end
         default: clear_parser();
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [7:0] index_byte();
      int k;
      k = int'(offset_cfg) + int'($urandom_range(9));
      if (k > 255 || $urandom_range(3) == 0)
         return 8'($urandom_range(255));
      return 8'(k);
   endfunction

   function automatic logic [7:0] value_byte();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0)
         return 8'd0;
      if (pick == 1)
         return 8'd100;
      if (pick == 2)
         return 8'($urandom_range(101, 255));
      return 8'($urandom_range(100));
   endfunction

   // Offers one item with random idle cycles ahead of it, then updates the predicted state.
   task automatic offer_byte(input logic [7:0] b, input bit keep_predicted);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_link.valid <= 1'b0;
         @(posedge clock);
      end
      req_link.valid   <= 1'b1;
      req_link.rx_byte <= b;
      @(posedge clock);
      while (req_link.ready !== 1'b1) @(posedge clock);
      take_byte(b);
      if (keep_predicted) begin
         foreach (replies_new[i])
            replies_due.push_back(replies_new[i]);
      end
      phase_items++;
   endtask

   task automatic wait_for_replies();
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // On a read, data holds the value the register should return.
   task automatic csr_access(input bit is_write, input logic [2:0] addr, input logic [31:0] data);
      logic [31:0] mask;
      mask    = (addr == ADDR_LAMP_COUNT) ? 32'h0000_000F : 32'h0000_00FF;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= is_write ? data : 32'd0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (!is_write && (prdata & mask) !== (data & mask)) begin
         $error("%s: expected %0d, got %0d",
                (addr == ADDR_LAMP_COUNT) ? "lamp_count" : "index_offset",
                data & mask, prdata & mask);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic retune(input logic [3:0] lamps, input logic [7:0] offset);
      req_link.valid <= 1'b0;
      wait_for_replies();
      // A set with a bad value leaves nothing to wait for, so allow the run to finish.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, ADDR_LAMP_COUNT, {28'd0, lamps});
      csr_access(1'b1, ADDR_INDEX_OFFSET, {24'd0, offset});
      csr_access(1'b0, ADDR_LAMP_COUNT, {28'd0, lamps});
      csr_access(1'b0, ADDR_INDEX_OFFSET, {24'd0, offset});
      count_cfg  = lamps;
      offset_cfg = offset;
   endtask

   // One command run: mostly well formed, with stray, missing and extra bytes mixed in.
   task automatic send_command();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         offer_byte(BYTE_COUNT, 1'b1);
         if ($urandom_range(9) == 0)
            offer_byte(8'($urandom_range(255)), 1'b1);
         offer_byte(BYTE_EXEC, 1'b1);
      end else if (pick < 45) begin
         offer_byte(BYTE_GET, 1'b1);
         if ($urandom_range(9) < 7)
            offer_byte(index_byte(), 1'b1);
         if ($urandom_range(9) < 2)
            offer_byte(8'($urandom_range(255)), 1'b1);
         offer_byte(BYTE_EXEC, 1'b1);
      end else if (pick < 85) begin
         offer_byte(BYTE_SET, 1'b1);
         if ($urandom_range(19) != 0)
            offer_byte(value_byte(), 1'b1);
         if ($urandom_range(9) < 7)
            offer_byte(index_byte(), 1'b1);
         if ($urandom_range(9) == 0)
            offer_byte(8'($urandom_range(255)), 1'b1);
         offer_byte(BYTE_EXEC, 1'b1);
      end else begin
         repeat ($urandom_range(1, 3))
            offer_byte(8'($urandom_range(255)), 1'b1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_link.valid === 1'b1 && rsp_link.ready === 1'b1) begin
         if (replies_due.size() == 0) begin
            $error("result with nothing pending: kind %0d data_byte %0d lamp_index %0d",
                   rsp_link.kind, rsp_link.data_byte, rsp_link.lamp_index);
            mismatch_count++;
         end else begin
            reply_now = replies_due.pop_front();
            check_field("kind", reply_now.kind, rsp_link.kind);
            check_field("data_byte", reply_now.data_byte, rsp_link.data_byte);
            check_field("lamp_index", reply_now.lamp_index, rsp_link.lamp_index);
            check_field("last", reply_now.last, rsp_link.last);
         end
      end
   end

   // Receiver: random stalls, none while steady, and a long hold when asked for.
   initial begin
      rsp_link.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_link.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_link.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_link.valid   = 1'b0;
      req_link.rx_byte = 8'd0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      foreach (level_copy[i])
         level_copy[i] = '0;
      count_cfg  = LAMP_COUNT_RESET;
      offset_cfg = 8'd0;
      clear_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         offer_byte(DIRECTED[i].rx_byte, !DIRECTED[i].typed);
         if (DIRECTED[i].typed && DIRECTED[i].n_typed > 0)
            replies_due.push_back(DIRECTED[i].first);
         if (DIRECTED[i].typed && DIRECTED[i].n_typed > 1)
            replies_due.push_back(DIRECTED[i].second);
      end

      foreach (PHASES[p]) begin
         retune(PHASES[p].lamps, PHASES[p].offset);
         steady      = PHASES[p].steady;
         phase_items = 0;
         if (PHASES[p].squeeze) begin
            // All-lamp queries pile up behind a receiver that holds off.
            hold_cycles = LONG_HOLD;
            repeat (8) begin
               offer_byte(BYTE_GET, 1'b1);
               offer_byte(BYTE_EXEC, 1'b1);
            end
            req_link.valid <= 1'b0;
            wait_for_replies();
         end
         while (phase_items < ITEMS_PER_PHASE)
            send_command();
         // Leave the parser idle before the registers change.
         offer_byte(BYTE_EXEC, 1'b1);
         steady = 1'b0;
      end

      req_link.valid <= 1'b0;
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
